// ===== rtl/hsv_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv_pkg: shared types and helpers for the HSV to RGB converter
// Pixel structs, the sideband structs that ride along the pipeline, the
// channel source codes, the sector table and the divide-by-255 helper.
// ----------------------------------------------------------------------------
package hsv_pkg;

  localparam int unsigned HUE_W  = 13;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned PROD_W = 16;   // 8x8 channel products
  localparam int unsigned SEC_W  = 3;

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  // Input item: one HSV pixel
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  brightness;
  } pixel_in_t;

  // Result item: one RGB pixel
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_out_t;

  // Carried alongside the hue divider
  typedef struct packed {
    logic [PROD_W-1:0] sv;     // S*V
    logic [PROD_W-1:0] base;   // V*(255-S)
    logic [CH_W-1:0]   val;
  } front_side_t;

  // Carried alongside the x-channel divider
  typedef struct packed {
    logic [SEC_W-1:0] sector;
    logic [CH_W-1:0]  min_ch;
    logic [CH_W-1:0]  val;
  } mix_side_t;

  // Where each output channel takes its value from
  typedef enum logic [1:0] {
    SRC_MIN    = 2'd0,
    SRC_X      = 2'd1,
    SRC_CHROMA = 2'd2
  } src_e;

  // Sector codes
  localparam logic [SEC_W-1:0] SEC_RY = 3'd0;
  localparam logic [SEC_W-1:0] SEC_YG = 3'd1;
  localparam logic [SEC_W-1:0] SEC_GC = 3'd2;
  localparam logic [SEC_W-1:0] SEC_CB = 3'd3;
  localparam logic [SEC_W-1:0] SEC_BM = 3'd4;
  localparam logic [SEC_W-1:0] SEC_MR = 3'd5;

  // floor(y/255) for y below 65280, so that the result fits in 8 bits
  function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] y);
    logic [PROD_W:0] t;
    t = {1'b0, y} + {9'd0, y[PROD_W-1:CH_W]} + 17'd1;
    return t[PROD_W-1:CH_W];
  endfunction

  // Source order {red, green, blue} per 60-degree sector
  function automatic logic [5:0] sector_map(input logic [SEC_W-1:0] sec);
    logic [5:0] m;
    case (sec)
      SEC_RY:  m = {SRC_CHROMA, SRC_X,      SRC_MIN};
      SEC_YG:  m = {SRC_X,      SRC_CHROMA, SRC_MIN};
      SEC_GC:  m = {SRC_MIN,    SRC_CHROMA, SRC_X};
      SEC_CB:  m = {SRC_MIN,    SRC_X,      SRC_CHROMA};
      SEC_BM:  m = {SRC_X,      SRC_MIN,    SRC_CHROMA};
      SEC_MR:  m = {SRC_CHROMA, SRC_MIN,    SRC_X};
      default: m = {SRC_MIN,    SRC_MIN,    SRC_MIN};
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/hsv_front.sv =====
// ----------------------------------------------------------------------------
// hsv_front: input stage
// Registers the hue and forms the two channel products S*V and V*(255-S).
// ----------------------------------------------------------------------------
module hsv_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  hsv_pkg::pixel_in_t       pix_i,
  output logic                     valid_o,
  output logic [hsv_pkg::HUE_W-1:0] hue_o,
  output hsv_pkg::front_side_t     side_o
);
  import hsv_pkg::*;

  logic              valid_q;
  logic [HUE_W-1:0]  hue_q;
  front_side_t       side_q, side_d;

  // products of the two fractions
  always_comb begin
    side_d.sv   = PROD_W'(pix_i.saturation) * PROD_W'(pix_i.brightness);
    side_d.base = PROD_W'(pix_i.brightness) * PROD_W'(CH_MAX - pix_i.saturation);
    side_d.val  = pix_i.brightness;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q  <= pix_i.hue;
    side_q <= side_d;
  end

  assign valid_o = valid_q;
  assign hue_o   = hue_q;
  assign side_o  = side_q;

endmodule

// ===== rtl/hsv_cdiv.sv =====
// ----------------------------------------------------------------------------
// hsv_cdiv: pipelined divide by a constant
// Three stages: reciprocal multiply, back multiply, one-step correction.
// The estimate is never more than one below the true quotient.
// ----------------------------------------------------------------------------
module hsv_cdiv #(
  parameter int unsigned DIVISOR = 120,
  parameter int unsigned IN_W    = 13,
  parameter int unsigned SIDE_W  = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [IN_W-1:0]            num_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic [IN_W-1:0]            quot_o,
  output logic [$clog2(DIVISOR)-1:0] rem_o,
  output logic [SIDE_W-1:0]          side_o
);
  import hsv_pkg::*;

  localparam int unsigned     SH    = IN_W;
  localparam longint unsigned MUL_L = (64'd1 << SH) / DIVISOR;
  localparam int unsigned     MW    = $clog2(MUL_L + 1);
  localparam int unsigned     PW    = IN_W + MW;
  localparam int unsigned     DW    = $clog2(DIVISOR + 1);
  localparam int unsigned     RW    = $clog2(DIVISOR);
  localparam logic [MW-1:0]   MUL   = MW'(MUL_L);

  logic              v1_q, v2_q, v3_q;
  logic [PW-1:0]     prod_q;
  logic [IN_W-1:0]   num1_q, num2_q;
  logic [SIDE_W-1:0] side1_q, side2_q, side3_q;
  logic [IN_W-1:0]   q0_d, q0_q, back_d, back_q;
  logic [IN_W-1:0]   r0, quot_d, quot_q;
  logic [RW-1:0]     rem_d, rem_q;

  // stage 2: quotient estimate and its multiple, registered side by side
  always_comb begin
    q0_d   = IN_W'(prod_q >> SH);
    back_d = IN_W'((IN_W + DW)'(q0_d) * (IN_W + DW)'(DIVISOR));
  end

  // stage 3: fix an estimate that is one short
  always_comb begin
    r0 = num2_q - back_q;
    if (r0 >= IN_W'(DIVISOR)) begin
      quot_d = q0_q + IN_W'(1);
      rem_d  = RW'(r0 - IN_W'(DIVISOR));
    end else begin
      quot_d = q0_q;
      rem_d  = RW'(r0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= PW'(num_i) * PW'(MUL);
    num1_q  <= num_i;
    side1_q <= side_i;
    q0_q    <= q0_d;
    back_q  <= back_d;
    num2_q  <= num1_q;
    side2_q <= side1_q;
    quot_q  <= quot_d;
    rem_q   <= rem_d;
    side3_q <= side2_q;
  end

  assign valid_o = v3_q;
  assign quot_o  = quot_q;
  assign rem_o   = rem_q;
  assign side_o  = side3_q;

endmodule

// ===== rtl/hsv_mix.sv =====
// ----------------------------------------------------------------------------
// hsv_mix: hue ramp and x-channel numerator
// Folds the hue into a ramp k, picks the sector and forms
// S*V*k + V*(255-S)*P over two stages.
// ----------------------------------------------------------------------------
module hsv_mix #(
  parameter int unsigned PERIOD = 960,
  parameter int unsigned HM_W   = 11,
  parameter int unsigned NUM_W  = 26
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [7:0]           quot_i,
  input  logic [HM_W-1:0]      rem_i,
  input  hsv_pkg::front_side_t side_i,
  output logic                 valid_o,
  output logic [NUM_W-1:0]     num_o,
  output hsv_pkg::mix_side_t   side_o
);
  import hsv_pkg::*;

  localparam int unsigned KW = $clog2(PERIOD + 1);
  localparam int unsigned MW = PROD_W + KW;

  logic              upper;
  logic [HM_W-1:0]   ramp_off;
  logic [KW-1:0]     k;
  logic [15:0]       q3_prod;
  logic [7:0]        m3;
  mix_side_t         sa_d, sa_q, sb_q;
  logic [MW-1:0]     svk_q, bp_q;
  logic [NUM_W-1:0]  num_q;
  logic              va_q, vb_q;

  // stage A: ramp, sector and products
  always_comb begin
    upper    = (rem_i >= HM_W'(PERIOD));
    ramp_off = upper ? (rem_i - HM_W'(PERIOD)) : (HM_W'(PERIOD) - rem_i);
    k        = KW'(HM_W'(PERIOD) - ramp_off);
    // pair index mod 3; quotient by 3 via 171/512
    q3_prod = 16'(quot_i) * 16'd171;
    m3      = quot_i - 8'(q3_prod[15:9] * 7'd3);
    sa_d.sector = {m3[1:0], upper};
    sa_d.min_ch = div255(side_i.base);
    sa_d.val    = side_i.val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    svk_q <= MW'(side_i.sv) * MW'(k);
    bp_q  <= MW'(side_i.base) * MW'(PERIOD);
    sa_q  <= sa_d;
    // stage B: sum of the two terms
    num_q <= NUM_W'(svk_q) + NUM_W'(bp_q);
    sb_q  <= sa_q;
  end

  assign valid_o = vb_q;
  assign num_o   = num_q;
  assign side_o  = sb_q;

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter: pipelined HSV to RGB pixel conversion
// Converts one HSV pixel per clock into its RGB channels.
// ----------------------------------------------------------------------------
// Usage:
//   Drive an HSV item on hsv_i with start high; it is taken at that edge.
//   busy is tied low: the pipeline takes one item every clock.
//   The RGB item appears on rgb_o with valid_o high for exactly one cycle,
//   and items leave in the order in which they were taken.
//   Stages: 1 input products, 3 hue divide by 120 degrees, 2 ramp and
//   numerator, 3 divide by 60 degrees, 1 channel select and output register.
//   Throughput is one item per cycle; only the mod-3 sector step in the
//   ramp stage chains one multiplier into another, and the two constant
//   dividers are reciprocal multiplies with a one-step correction.
//   The receiver cannot stall; results are dropped if not sampled.
//   Reset clears every stage valid bit, so no stray result follows reset.
//   Hue values at or past 360 degrees wrap around the color circle.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter #(
  parameter int unsigned HUE_STEPS_PER_DEGREE = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  hsv_pkg::pixel_in_t  hsv_i,
  output logic                valid_o,
  output hsv_pkg::pixel_out_t rgb_o
);
  import hsv_pkg::*;

  localparam int unsigned     P       = 60 * HUE_STEPS_PER_DEGREE;
  localparam int unsigned     P2      = 2 * P;
  localparam int unsigned     HM_W    = $clog2(P2);
  localparam longint unsigned NUM_MAX = 64'd65025 * P;
  localparam int unsigned     NUM_W   = $clog2(NUM_MAX + 1);

  logic                      f_valid, h_valid, m_valid, d_valid;
  logic [HUE_W-1:0]          f_hue, h_quot;
  front_side_t               f_side, h_side_s;
  logic [$bits(front_side_t)-1:0] h_side;
  logic [HM_W-1:0]           h_rem;
  logic [NUM_W-1:0]          m_num, d_quot;
  mix_side_t                 m_side, d_side_s;
  logic [$bits(mix_side_t)-1:0]   d_side;
  logic [CH_W-1:0]           x_ch;
  logic [5:0]                srcs;
  pixel_out_t                rgb_d, rgb_q;
  logic                      valid_q;

  assign busy = 1'b0;

  // input products
  hsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .pix_i   (hsv_i),
    .valid_o (f_valid),
    .hue_o   (f_hue),
    .side_o  (f_side)
  );

  // hue split into 120-degree pairs and offset
  hsv_cdiv #(
    .DIVISOR (P2),
    .IN_W    (HUE_W),
    .SIDE_W  ($bits(front_side_t))
  ) u_hue_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .num_i   (f_hue),
    .side_i  (f_side),
    .valid_o (h_valid),
    .quot_o  (h_quot),
    .rem_o   (h_rem),
    .side_o  (h_side)
  );
  assign h_side_s = front_side_t'(h_side);

  // ramp and numerator
  hsv_mix #(
    .PERIOD (P),
    .HM_W   (HM_W),
    .NUM_W  (NUM_W)
  ) u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (h_valid),
    .quot_i  (h_quot[7:0]),
    .rem_i   (h_rem),
    .side_i  (h_side_s),
    .valid_o (m_valid),
    .num_o   (m_num),
    .side_o  (m_side)
  );

  // numerator over P; the division by 255 follows
  hsv_cdiv #(
    .DIVISOR (P),
    .IN_W    (NUM_W),
    .SIDE_W  ($bits(mix_side_t))
  ) u_x_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_valid),
    .num_i   (m_num),
    .side_i  (m_side),
    .valid_o (d_valid),
    .quot_o  (d_quot),
    .rem_o   (),
    .side_o  (d_side)
  );
  assign d_side_s = mix_side_t'(d_side);

  function automatic logic [CH_W-1:0] pick(input src_e s);
    logic [CH_W-1:0] c;
    case (s)
      SRC_MIN:    c = d_side_s.min_ch;
      SRC_X:      c = x_ch;
      SRC_CHROMA: c = d_side_s.val;
      default:    c = d_side_s.min_ch;
    endcase
    return c;
  endfunction

  // x channel and per-sector channel order
  always_comb begin
    x_ch = div255(d_quot[PROD_W-1:0]);
    srcs = sector_map(d_side_s.sector);
    rgb_d.red   = pick(src_e'(srcs[5:4]));
    rgb_d.green = pick(src_e'(srcs[3:2]));
    rgb_d.blue  = pick(src_e'(srcs[1:0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rgb_q <= rgb_d;
  end

  assign valid_o = valid_q;
  assign rgb_o   = rgb_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for hsv_to_rgb_converter
// A short directed table comes first: black, white, the primary and secondary
// colors, sector edges and hues past 360 degrees. Random HSV items follow.
// Each RGB result is checked in order against a typed-in value or an in-bench HSV to RGB model.
// ----------------------------------------------------------------------------
module testbench;
  import hsv_pkg::*;

  localparam int unsigned STEPS_PER_DEG = 16;
  localparam int unsigned SECTOR_SPAN   = 60 * STEPS_PER_DEG;   // 60 degrees in hue steps
  localparam int unsigned HUE_FULL      = 6 * SECTOR_SPAN;      // 360 degrees
  localparam int unsigned HUE_TOP       = (1 << HUE_W) - 1;
  localparam int unsigned RANDOM_ITEMS  = 1900;
  localparam int unsigned PIPE_LATENCY  = 10;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DIR_N         = 19;

  // One directed row: HSV item, whether the RGB value is typed in, the RGB value
  typedef struct packed {
    pixel_in_t  px;
    logic       known;
    pixel_out_t rgb;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  pixel_in_t  hsv_i;
  logic       valid_o;
  pixel_out_t rgb_o;

  pixel_out_t  rgb_pending_q[$];
  int unsigned items_sent;
  int unsigned pixels_checked;
  int unsigned wrapped_hues;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned burst_left;

  // Directed stimulus: {hue, saturation, brightness, known, {red, green, blue}}
  dir_row_t dir_table [DIR_N] = '{
    {13'd0,    8'd0,   8'd0,   1'b1, {8'd0,   8'd0,   8'd0}},    // black
    {13'd0,    8'd0,   8'd255, 1'b1, {8'd255, 8'd255, 8'd255}},  // white
    {13'd0,    8'd255, 8'd255, 1'b1, {8'd255, 8'd0,   8'd0}},    // red
    {13'd480,  8'd255, 8'd255, 1'b1, {8'd255, 8'd127, 8'd0}},    // orange, x truncated
    {13'd960,  8'd255, 8'd255, 1'b1, {8'd255, 8'd255, 8'd0}},    // yellow
    {13'd1920, 8'd255, 8'd255, 1'b1, {8'd0,   8'd255, 8'd0}},    // green
    {13'd2880, 8'd255, 8'd255, 1'b1, {8'd0,   8'd255, 8'd255}},  // cyan
    {13'd3840, 8'd255, 8'd255, 1'b1, {8'd0,   8'd0,   8'd255}},  // blue
    {13'd4800, 8'd255, 8'd255, 1'b1, {8'd255, 8'd0,   8'd255}},  // magenta
    {13'd5759, 8'd255, 8'd255, 1'b1, {8'd255, 8'd0,   8'd0}},    // just under 360
    {13'd5760, 8'd255, 8'd255, 1'b1, {8'd255, 8'd0,   8'd0}},    // 360 wraps to red
    {13'd8191, 8'd255, 8'd255, 1'b0, {8'd0,   8'd0,   8'd0}},    // top hue code
    {13'd1234, 8'd0,   8'd128, 1'b1, {8'd128, 8'd128, 8'd128}},  // gray, hue ignored
    {13'd2500, 8'd255, 8'd0,   1'b1, {8'd0,   8'd0,   8'd0}},    // zero value
    {13'd0,    8'd255, 8'd1,   1'b1, {8'd1,   8'd0,   8'd0}},    // faintest red
    {13'd959,  8'd128, 8'd200, 1'b0, {8'd0,   8'd0,   8'd0}},
    {13'd4321, 8'd1,   8'd1,   1'b0, {8'd0,   8'd0,   8'd0}},
    {13'd7000, 8'd170, 8'd85,  1'b0, {8'd0,   8'd0,   8'd0}},
    {13'd6143, 8'd77,  8'd250, 1'b0, {8'd0,   8'd0,   8'd0}}
  };

  hsv_to_rgb_converter #(
    .HUE_STEPS_PER_DEGREE(STEPS_PER_DEG)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .hsv_i  (hsv_i),
    .valid_o(valid_o),
    .rgb_o  (rgb_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Exact HSV to RGB conversion, integer form
  function automatic pixel_out_t convert_hsv(pixel_in_t px);
    int unsigned      s, v, hm, span_off, k, base;
    logic [SEC_W-1:0] sec;
    logic [CH_W-1:0]  min_ch, x_ch, c_ch;
    pixel_out_t       rgb;
    s        = px.saturation;
    v        = px.brightness;
    sec      = SEC_W'((px.hue / SECTOR_SPAN) % 6);
    hm       = px.hue % (2 * SECTOR_SPAN);
    span_off = (hm >= SECTOR_SPAN) ? hm - SECTOR_SPAN : SECTOR_SPAN - hm;
    k        = SECTOR_SPAN - span_off;
    base     = v * (255 - s);
    min_ch   = CH_W'(base / 255);
    x_ch     = CH_W'((s * v * k + base * SECTOR_SPAN) / (255 * SECTOR_SPAN));
    c_ch     = CH_W'(v);
    case (sec)
      SEC_RY:  rgb = {c_ch,   x_ch,   min_ch};
      SEC_YG:  rgb = {x_ch,   c_ch,   min_ch};
      SEC_GC:  rgb = {min_ch, c_ch,   x_ch};
      SEC_CB:  rgb = {min_ch, x_ch,   c_ch};
      SEC_BM:  rgb = {x_ch,   min_ch, c_ch};
      default: rgb = {c_ch,   min_ch, x_ch};
    endcase
    return rgb;
  endfunction

  // Channel value biased toward the ends of the range
  function automatic logic [CH_W-1:0] pick_channel();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return CH_MAX;
    return CH_W'($urandom_range(0, 255));
  endfunction

  // Hue: mostly in range, some near sector edges, some past 360 degrees
  function automatic logic [HUE_W-1:0] pick_hue();
    int unsigned sel, edge_pt;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return HUE_W'($urandom_range(0, HUE_FULL - 1));
    if (sel <= 7) begin
      edge_pt = $urandom_range(0, 8) * SECTOR_SPAN + $urandom_range(0, 4);
      return HUE_W'((edge_pt >= 2) ? edge_pt - 2 : edge_pt);
    end
    if (sel == 8) return HUE_W'($urandom_range(HUE_FULL, HUE_TOP));
    return HUE_W'($urandom_range(0, HUE_TOP));
  endfunction

  // Idle with start low; n sets the length of the gap
  task automatic idle_for(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // Burst pacing: random burst lengths with random gaps, some with no gap
  task automatic pace();
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 6));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  // Present one item and hold it until the accepting edge
  task automatic send_pixel(pixel_in_t px, logic known, pixel_out_t rgb);
    @(negedge clk_i);
    start <= 1'b1;
    hsv_i <= px;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    rgb_pending_q.insert(rgb_pending_q.size(), known ? rgb : convert_hsv(px));
    items_sent++;
    if (px.hue >= HUE_FULL) wrapped_hues++;
  endtask

  // Hold off until every expected pixel has come out
  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (rgb_pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Result checker: every strobed pixel against the oldest expectation
  always @(posedge clk_i) begin
    pixel_out_t exp_rgb;
    if (rst_ni && valid_o) begin
      if (rgb_pending_q.size() == 0) begin
        $error("unexpected RGB pixel %h with nothing pending", rgb_o);
        mismatches++;
      end else begin
        exp_rgb = rgb_pending_q.pop_front();
        pixels_checked++;
        if (rgb_o.red !== exp_rgb.red) begin
          $error("red: expected %0d, got %0d", exp_rgb.red, rgb_o.red);
          mismatches++;
        end
        if (rgb_o.green !== exp_rgb.green) begin
          $error("green: expected %0d, got %0d", exp_rgb.green, rgb_o.green);
          mismatches++;
        end
        if (rgb_o.blue !== exp_rgb.blue) begin
          $error("blue: expected %0d, got %0d", exp_rgb.blue, rgb_o.blue);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hsv_to_rgb_converter test failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    pixel_in_t px;
    items_sent     = 0;
    pixels_checked = 0;
    wrapped_hues   = 0;
    mismatches     = 0;
    cycle_count    = 0;
    burst_left     = 0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    hsv_i          = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    for (int i = 0; i < DIR_N; i++) begin
      pace();
      send_pixel(dir_table[i].px, dir_table[i].known, dir_table[i].rgb);
    end
    wait_drained();

    // Random items, with one full drain halfway through
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) wait_drained();
      pace();
      px.hue        = pick_hue();
      px.saturation = pick_channel();
      px.brightness = pick_channel();
      send_pixel(px, 1'b0, '0);
    end

    // Drain, then let the pipeline run out
    wait_drained();
    repeat (PIPE_LATENCY * 2) @(posedge clk_i);

    $display("Sent %0d HSV items (%0d directed), %0d with hue past 360 degrees.",
             items_sent, DIR_N, wrapped_hues);
    $display("Checked %0d RGB pixels, %0d field mismatches.", pixels_checked, mismatches);
    if (mismatches == 0 && rgb_pending_q.size() == 0) begin
      $display("hsv_to_rgb_converter test passed");
    end else begin
      $display("hsv_to_rgb_converter test failed");
    end
    $finish;
  end

endmodule
